[hw/rtl/llrr_pkg.sv]
package llrr_pkg;

    localparam int MAX_LAG     = 64;
    localparam int PTR_W       = $clog2(MAX_LAG);
    localparam int LEN_W       = $clog2(MAX_LAG + 1);
    localparam int SUM_W       = 32 + PTR_W;
    localparam int LATENCY     = 9;

    localparam int COEFF_W     = 17;
    localparam int GAIN_W      = 32;
    localparam int LAG_CFG_W   = 7;
    localparam int DATA_W      = 32;
    localparam int VOL_W       = 48;
    localparam int ADDR_W      = 4;

    localparam logic [COEFF_W-1:0]   INFLOW_COEFF_RST    = 17'd32768;
    localparam logic [COEFF_W-1:0]   RECESSION_COEFF_RST = 17'd0;
    localparam logic [GAIN_W-1:0]    STORAGE_GAIN_RST    = 32'd65536;
    localparam logic [LAG_CFG_W-1:0] LAG_STEPS_RST       = 7'd1;

    typedef enum logic [1:0] {
        REG_INFLOW_COEFF    = 2'd0,
        REG_RECESSION_COEFF = 2'd1,
        REG_STORAGE_GAIN    = 2'd2,
        REG_LAG_STEPS       = 2'd3
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_OLD,
        S_REL,
        S_OUT,
        S_MUL2,
        S_SRND,
        S_GMUL,
        S_GSUM,
        S_VOL
    } t_state;

    typedef struct packed {
        logic [COEFF_W-1:0]   inflow_coeff;
        logic [COEFF_W-1:0]   recession_coeff;
        logic [GAIN_W-1:0]    storage_gain;
        logic [LAG_CFG_W-1:0] lag_steps;
    } t_cfg;

    typedef struct packed {
        logic take;
        logic upd;
        logic rel;
        logic outc;
        logic mul2;
        logic srnd;
        logic gmul;
        logic gsum;
        logic load;
    } t_cmd;

endpackage

[hw/rtl/llrr_cfg.sv]
module llrr_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [llrr_pkg::ADDR_W-1:0]         paddr,
    input  logic [llrr_pkg::DATA_W-1:0]         pwdata,
    output logic [llrr_pkg::DATA_W-1:0]         prdata,
    output logic                                pready,
    output llrr_pkg::t_cfg                      o_cfg
);

    llrr_pkg::t_cfg     r_cfg;
    llrr_pkg::t_reg_idx w_idx;
    logic               w_wr;

    assign w_idx  = llrr_pkg::t_reg_idx'(paddr[3:2]);
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.inflow_coeff    <= llrr_pkg::INFLOW_COEFF_RST;
            r_cfg.recession_coeff <= llrr_pkg::RECESSION_COEFF_RST;
            r_cfg.storage_gain    <= llrr_pkg::STORAGE_GAIN_RST;
            r_cfg.lag_steps       <= llrr_pkg::LAG_STEPS_RST;
        end else if (w_wr) begin
            case (w_idx)
                llrr_pkg::REG_INFLOW_COEFF: begin
                    r_cfg.inflow_coeff <= pwdata[llrr_pkg::COEFF_W-1:0];
                end
                llrr_pkg::REG_RECESSION_COEFF: begin
                    r_cfg.recession_coeff <= pwdata[llrr_pkg::COEFF_W-1:0];
                end
                llrr_pkg::REG_STORAGE_GAIN: begin
                    r_cfg.storage_gain <= pwdata[llrr_pkg::GAIN_W-1:0];
                end
                llrr_pkg::REG_LAG_STEPS: begin
                    r_cfg.lag_steps <= pwdata[llrr_pkg::LAG_CFG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            llrr_pkg::REG_INFLOW_COEFF: begin
                prdata = llrr_pkg::DATA_W'(r_cfg.inflow_coeff);
            end
            llrr_pkg::REG_RECESSION_COEFF: begin
                prdata = llrr_pkg::DATA_W'(r_cfg.recession_coeff);
            end
            llrr_pkg::REG_STORAGE_GAIN: begin
                prdata = r_cfg.storage_gain;
            end
            llrr_pkg::REG_LAG_STEPS: begin
                prdata = llrr_pkg::DATA_W'(r_cfg.lag_steps);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

endmodule

[hw/rtl/llrr_ctrl.sv]
module llrr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output llrr_pkg::t_cmd  o_cmd
);

    llrr_pkg::t_state r_state;
    llrr_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             w_free;

    // the result register can take a new value once it is empty or being drained
    assign w_free      = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= llrr_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        case (r_state)
            llrr_pkg::S_IDLE: n_state = i_in_valid ? llrr_pkg::S_OLD : llrr_pkg::S_IDLE;
            llrr_pkg::S_OLD:  n_state = llrr_pkg::S_REL;
            llrr_pkg::S_REL:  n_state = llrr_pkg::S_OUT;
            llrr_pkg::S_OUT:  n_state = llrr_pkg::S_MUL2;
            llrr_pkg::S_MUL2: n_state = llrr_pkg::S_SRND;
            llrr_pkg::S_SRND: n_state = llrr_pkg::S_GMUL;
            llrr_pkg::S_GMUL: n_state = llrr_pkg::S_GSUM;
            llrr_pkg::S_GSUM: n_state = llrr_pkg::S_VOL;
            llrr_pkg::S_VOL:  n_state = w_free ? llrr_pkg::S_IDLE : llrr_pkg::S_VOL;
            default:          n_state = llrr_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            llrr_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.take = i_in_valid;
            end
            llrr_pkg::S_OLD:  o_cmd.upd  = 1'b1;
            llrr_pkg::S_REL:  o_cmd.rel  = 1'b1;
            llrr_pkg::S_OUT:  o_cmd.outc = 1'b1;
            llrr_pkg::S_MUL2: o_cmd.mul2 = 1'b1;
            llrr_pkg::S_SRND: o_cmd.srnd = 1'b1;
            llrr_pkg::S_GMUL: o_cmd.gmul = 1'b1;
            llrr_pkg::S_GSUM: o_cmd.gsum = 1'b1;
            llrr_pkg::S_VOL:  o_cmd.load = w_free;
            default: begin
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

endmodule

[hw/rtl/llrr_dp.sv]
module llrr_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  llrr_pkg::t_cfg                       i_cfg,
    input  llrr_pkg::t_cmd                       i_cmd,
    input  logic [31:0]                          i_inflow,
    output logic signed [31:0]                   o_outflow,
    output logic signed [llrr_pkg::VOL_W-1:0]    o_stored_volume
);

    localparam int PTR_W = llrr_pkg::PTR_W;
    localparam int LEN_W = llrr_pkg::LEN_W;
    localparam int SUM_W = llrr_pkg::SUM_W;

    // lag line
    logic [31:0]              r_mem [llrr_pkg::MAX_LAG];
    logic [llrr_pkg::MAX_LAG-1:0] r_valid;
    logic [31:0]              r_rdata;
    logic                     r_rd_vld;
    logic                     r_bypass;
    logic [PTR_W-1:0]         r_ptr;
    logic [SUM_W-1:0]         r_sum;
    logic [31:0]              r_inflow;

    // reservoir state and intermediates
    logic [31:0]              r_last_rel;
    logic signed [31:0]       r_outv;
    logic [31:0]              r_rel;
    logic [SUM_W-1:0]         r_lagc;
    logic [48:0]              r_qr;
    logic [48:0]              r_ql;
    logic signed [48:0]       r_q2;
    logic signed [48:0]       r_m;
    logic signed [34:0]       r_s;
    logic signed [51:0]       r_ph;
    logic signed [51:0]       r_pl;
    logic signed [52:0]       r_st;

    logic [LEN_W-1:0]         w_len;
    logic [LEN_W-1:0]         w_inc;
    logic [PTR_W-1:0]         w_nptr;
    logic [PTR_W-1:0]         w_rd_addr;
    logic [31:0]              w_old;
    logic [31:0]              w_rel;
    logic signed [51:0]       w_acc;
    logic signed [51:0]       w_acc_r;
    logic signed [35:0]       w_acc_q;
    logic signed [31:0]       w_outv;
    logic signed [50:0]       w_res;
    logic signed [50:0]       w_res_r;
    logic signed [51:0]       w_pl_r;
    logic signed [53:0]       w_vol;
    logic signed [llrr_pkg::VOL_W-1:0] w_vol_sat;
    logic signed [17:0]       w_c2;

    assign w_c2 = {i_cfg.recession_coeff[16], i_cfg.recession_coeff};

    // clamp the lag length to one .. MAX_LAG
    always_comb begin
        if (i_cfg.lag_steps == '0) begin
            w_len = LEN_W'(1);
        end else if (32'(i_cfg.lag_steps) > llrr_pkg::MAX_LAG) begin
            w_len = LEN_W'(llrr_pkg::MAX_LAG);
        end else begin
            w_len = LEN_W'(i_cfg.lag_steps);
        end
    end

    assign w_inc     = LEN_W'(r_ptr) + LEN_W'(1);
    assign w_nptr    = (w_inc >= w_len) ? '0 : w_inc[PTR_W-1:0];
    assign w_rd_addr = i_cmd.upd ? w_nptr : r_ptr;
    assign w_old     = r_rd_vld ? r_rdata : '0;
    assign w_rel     = r_bypass ? r_inflow : (r_rd_vld ? r_rdata : '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            r_mem[r_ptr] <= r_inflow;
        end
        if (i_cmd.take || i_cmd.upd) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_ptr      <= '0;
            r_sum      <= '0;
            r_last_rel <= '0;
            r_outv     <= '0;
        end else begin
            if (i_cmd.upd) begin
                r_valid[r_ptr] <= 1'b1;
                r_ptr          <= w_nptr;
                r_sum          <= r_sum - SUM_W'(w_old) + SUM_W'(r_inflow);
            end
            if (i_cmd.outc) begin
                r_outv     <= w_outv;
                r_last_rel <= r_rel;
            end
        end
    end

    // outflow: round half up, then saturate to 32 bits
    assign w_acc   = $signed({3'b000, r_qr}) + $signed({3'b000, r_ql})
                   + {{3{r_q2[48]}}, r_q2};
    assign w_acc_r = w_acc + 52'sd32768;
    assign w_acc_q = w_acc_r[51:16];

    always_comb begin
        if (w_acc_q[35:31] == 5'b00000 || w_acc_q[35:31] == 5'b11111) begin
            w_outv = w_acc_q[31:0];
        end else if (w_acc_q[35]) begin
            w_outv = 32'sh8000_0000;
        end else begin
            w_outv = 32'sh7FFF_FFFF;
        end
    end

    assign w_res   = $signed({2'b00, r_qr}) + {{2{r_m[48]}}, r_m};
    assign w_res_r = w_res + 51'sd32768;
    assign w_pl_r  = r_pl + 52'sd32768;
    assign w_vol   = $signed(54'(r_lagc)) + {r_st[52], r_st};

    always_comb begin
        if (w_vol[53:47] == 7'b0000000 || w_vol[53:47] == 7'b1111111) begin
            w_vol_sat = w_vol[llrr_pkg::VOL_W-1:0];
        end else if (w_vol[53]) begin
            w_vol_sat = {1'b1, {(llrr_pkg::VOL_W-1){1'b0}}};
        end else begin
            w_vol_sat = {1'b0, {(llrr_pkg::VOL_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_inflow <= i_inflow;
            r_rd_vld <= r_valid[r_ptr];
            r_ql     <= i_cfg.inflow_coeff * r_last_rel;
            r_q2     <= w_c2 * r_outv;
        end
        if (i_cmd.upd) begin
            r_rd_vld <= r_valid[w_nptr];
            r_bypass <= (w_nptr == r_ptr);
        end
        if (i_cmd.rel) begin
            r_rel  <= w_rel;
            r_qr   <= i_cfg.inflow_coeff * w_rel;
            r_lagc <= r_sum - SUM_W'(w_rel);
        end
        if (i_cmd.mul2) begin
            r_m <= w_c2 * r_outv;
        end
        if (i_cmd.srnd) begin
            r_s <= w_res_r[50:16];
        end
        if (i_cmd.gmul) begin
            r_ph <= r_s * $signed({1'b0, i_cfg.storage_gain[31:16]});
            r_pl <= r_s * $signed({1'b0, i_cfg.storage_gain[15:0]});
        end
        if (i_cmd.gsum) begin
            r_st <= {r_ph[51], r_ph} + {{17{w_pl_r[51]}}, w_pl_r[51:16]};
        end
        if (i_cmd.load) begin
            o_outflow       <= r_outv;
            o_stored_volume <= w_vol_sat;
        end
    end

endmodule

[hw/rtl/lag_and_linear_reservoir_routing.sv]
// One item at a time: the sequencer steps from S_OLD through S_VOL, walking the two
// lag-line reads through the single memory port and then the dependent multiply-round
// chain; S_VOL waits until the result register is free before it loads the result.
// The result register holds a finished result while the next item is taken in.
// Reset: i_rst_n is synchronous, active low; it restores the registers and clears
// the lag line at once through one valid bit per entry (no clearing pass).
module lag_and_linear_reservoir_routing (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [llrr_pkg::ADDR_W-1:0]          paddr,
    input  logic [llrr_pkg::DATA_W-1:0]          pwdata,
    output logic [llrr_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [31:0]                          i_inflow,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [31:0]                   o_outflow,
    output logic signed [llrr_pkg::VOL_W-1:0]    o_stored_volume
);

    llrr_pkg::t_cfg w_cfg;
    llrr_pkg::t_cmd w_cmd;

    llrr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    llrr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    llrr_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (w_cfg),
        .i_cmd           (w_cmd),
        .i_inflow        (i_inflow),
        .o_outflow       (o_outflow),
        .o_stored_volume (o_stored_volume)
    );

    // one item in flight at a time
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while an item is in flight");

    a_result_arrives: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |-> ##(llrr_pkg::LATENCY) o_out_valid)
        else $error("result missing after an input transfer");

    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared without an item in flight");

    a_one_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_cmd))
        else $error("more than one datapath command at once");

endmodule
